@@ hw/rtl/version_negotiation_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the version negotiation parser
// Implication checks clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef VERSION_NEGOTIATION_PARSER_ASSERT_SVH
`define VERSION_NEGOTIATION_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VNP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VNP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vnp_pkg.sv @@
// ----------------------------------------------------------------------------
// vnp_pkg
// Types, codes and constants shared by the version negotiation parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vnp_pkg;

    localparam int DEF_MAX_LINE   = 32;
    localparam int DEF_MAX_DIGITS = 9;

    localparam int VAL_W    = 30;
    localparam int VER_W    = 32;
    localparam int DIGCNT_W = 4;
    localparam int NAMELEN_W = 4;
    localparam int NAME_LEN  = 8;

    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_TOP   = 8'h5A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    localparam logic [VER_W-1:0] RST_MIN_SUPPORTED = 32'd1;
    localparam logic [VER_W-1:0] RST_MAX_SUPPORTED = 32'd1;

    // Expected protocol name, first character at index 0.
    localparam logic [7:0] NAME_TAG [NAME_LEN] = '{
        8'h41, 8'h4D, 8'h49, 8'h4B, 8'h4F, 8'h50, 8'h41, 8'h59
    };

    typedef enum logic [1:0] {
        CFG_SERVER_SIDE   = 2'd0,
        CFG_MIN_SUPPORTED = 2'd1,
        CFG_MAX_SUPPORTED = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        FLD_NAME = 2'd0,
        FLD_MIN  = 2'd1,
        FLD_MAX  = 2'd2
    } field_t;

    typedef enum logic [3:0] {
        ST_BUSY     = 4'd0,
        ST_OK       = 4'd1,
        ST_BADCHAR  = 4'd2,
        ST_TOOLONG  = 4'd3,
        ST_SLASH1   = 4'd4,
        ST_SLASH2   = 4'd5,
        ST_NAME     = 4'd6,
        ST_MINLONG  = 4'd7,
        ST_MAXLONG  = 4'd8,
        ST_BADDIGIT = 4'd9,
        ST_WEIRD    = 4'd10,
        ST_ILLEGAL  = 4'd11,
        ST_NOMATCH  = 4'd12
    } status_t;

    typedef struct packed {
        logic             server_side;
        logic [VER_W-1:0] min_supported;
        logic [VER_W-1:0] max_supported;
    } cfg_t;

    // Line summary handed to the matching logic on a newline.
    typedef struct packed {
        field_t              field_index;
        logic                last_was_slash;
        logic                name_ok;
        logic [DIGCNT_W-1:0] min_digits;
        logic [DIGCNT_W-1:0] max_digits;
        logic                digit_error;
        logic [VAL_W-1:0]    min_value;
        logic [VAL_W-1:0]    max_value;
    } line_sum_t;

    typedef struct packed {
        logic             done_res;
        status_t          status;
        logic [VER_W-1:0] negotiated_version;
        logic             send_reply;
        logic [VER_W-1:0] reply_min;
        logic [VER_W-1:0] reply_max;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/vnp_match.sv @@
// ----------------------------------------------------------------------------
// vnp_match
// End-of-line checks and server/client version matching rule.
// ----------------------------------------------------------------------------
`default_nettype none

module vnp_match #(
    parameter int MAX_DIGITS = vnp_pkg::DEF_MAX_DIGITS
) (
    input  wire vnp_pkg::line_sum_t sum,
    input  wire vnp_pkg::cfg_t      cfg,
    output vnp_pkg::res_t           res
);

    localparam logic [vnp_pkg::DIGCNT_W-1:0] DIG_LIMIT = vnp_pkg::DIGCNT_W'(MAX_DIGITS);

    logic [vnp_pkg::VER_W-1:0] min_v;
    logic [vnp_pkg::VER_W-1:0] max_v;
    logic [vnp_pkg::VER_W-1:0] lo;
    logic [vnp_pkg::VER_W-1:0] hi;

    assign min_v = vnp_pkg::VER_W'(sum.min_value);
    assign max_v = vnp_pkg::VER_W'(sum.max_value);
    assign lo    = (min_v > cfg.min_supported) ? min_v : cfg.min_supported;
    assign hi    = (max_v < cfg.max_supported) ? max_v : cfg.max_supported;

    always_comb begin
        res          = '0;
        res.done_res = 1'b1;
        res.status   = vnp_pkg::ST_OK;
        if (sum.field_index == vnp_pkg::FLD_NAME ||
            (sum.field_index == vnp_pkg::FLD_MIN && sum.last_was_slash)) begin
            res.status = vnp_pkg::ST_SLASH1;
        end else if (sum.field_index == vnp_pkg::FLD_MIN || sum.last_was_slash) begin
            res.status = vnp_pkg::ST_SLASH2;
        end else if (!sum.name_ok) begin
            res.status = vnp_pkg::ST_NAME;
        end else if (sum.min_digits > DIG_LIMIT) begin
            res.status = vnp_pkg::ST_MINLONG;
        end else if (sum.max_digits > DIG_LIMIT) begin
            res.status = vnp_pkg::ST_MAXLONG;
        end else if (sum.digit_error) begin
            res.status = vnp_pkg::ST_BADDIGIT;
        end else if (cfg.server_side) begin
            if (min_v > max_v) begin
                res.status = vnp_pkg::ST_WEIRD;
            end else begin
                res.send_reply = 1'b1;
                if (lo > hi) begin
                    res.status    = vnp_pkg::ST_NOMATCH;
                    res.reply_min = lo;
                    res.reply_max = hi;
                end else begin
                    res.negotiated_version = hi;
                    res.reply_min          = hi;
                    res.reply_max          = hi;
                end
            end
        end else begin
            if (min_v < cfg.min_supported || max_v > cfg.max_supported) begin
                res.status = vnp_pkg::ST_ILLEGAL;
            end else if (min_v < max_v) begin
                res.status = vnp_pkg::ST_WEIRD;
            end else if (min_v > max_v) begin
                res.status = vnp_pkg::ST_NOMATCH;
            end else begin
                res.negotiated_version = min_v;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/vnp_line.sv @@
// ----------------------------------------------------------------------------
// vnp_line
// Per-byte line state: length, slashes, name compare and version accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module vnp_line #(
    parameter int MAX_LINE   = vnp_pkg::DEF_MAX_LINE,
    parameter int MAX_DIGITS = vnp_pkg::DEF_MAX_DIGITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic [7:0]    rx_byte,
    input  wire vnp_pkg::cfg_t cfg,
    output vnp_pkg::res_t      res
);

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam logic [CNT_W:0] LINE_LIMIT = (CNT_W + 1)'(MAX_LINE);
    localparam logic [vnp_pkg::DIGCNT_W-1:0] DIG_LIMIT = vnp_pkg::DIGCNT_W'(MAX_DIGITS);
    localparam logic [vnp_pkg::DIGCNT_W-1:0] DIG_SAT   = '1;
    localparam logic [vnp_pkg::NAMELEN_W-1:0] NAME_SAT = '1;
    localparam logic [vnp_pkg::NAMELEN_W-1:0] NAME_FULL =
        vnp_pkg::NAMELEN_W'(vnp_pkg::NAME_LEN);

    logic [CNT_W-1:0]              byte_cnt_reg, byte_cnt_next;
    vnp_pkg::field_t               field_reg, field_next;
    logic [vnp_pkg::NAMELEN_W-1:0] name_len_reg, name_len_next;
    logic                          name_match_reg, name_match_next;
    logic                          slash_reg, slash_next;
    logic [vnp_pkg::VAL_W-1:0]     min_val_reg, min_val_next;
    logic [vnp_pkg::VAL_W-1:0]     max_val_reg, max_val_next;
    logic [vnp_pkg::DIGCNT_W-1:0]  min_dig_reg, min_dig_next;
    logic [vnp_pkg::DIGCNT_W-1:0]  max_dig_reg, max_dig_next;
    logic                          dig_err_reg, dig_err_next;

    logic                      is_nl;
    logic                      is_bad;
    logic                      is_digit;
    logic                      is_sep;
    logic                      too_long;
    logic [CNT_W:0]            cnt_inc;
    logic [vnp_pkg::VAL_W-1:0] min_acc;
    logic [vnp_pkg::VAL_W-1:0] max_acc;
    logic                      clear;
    vnp_pkg::line_sum_t        sum;
    vnp_pkg::res_t             match_res;

    assign is_nl    = (rx_byte == vnp_pkg::CHR_NL);
    assign is_bad   = (rx_byte < vnp_pkg::CHR_SLASH) || (rx_byte > vnp_pkg::CHR_TOP);
    assign is_digit = (rx_byte >= vnp_pkg::CHR_ZERO) && (rx_byte <= vnp_pkg::CHR_NINE);
    assign is_sep   = (rx_byte == vnp_pkg::CHR_SLASH) && (field_reg != vnp_pkg::FLD_MAX);
    assign cnt_inc  = {1'b0, byte_cnt_reg} + (CNT_W + 1)'(1);
    assign too_long = (cnt_inc >= LINE_LIMIT);
    assign clear    = is_nl || is_bad || too_long;

    // value * 10 + digit, kept to the low value bits
    assign min_acc = (min_val_reg << 3) + (min_val_reg << 1)
                   + vnp_pkg::VAL_W'(rx_byte[3:0]);
    assign max_acc = (max_val_reg << 3) + (max_val_reg << 1)
                   + vnp_pkg::VAL_W'(rx_byte[3:0]);

    always_comb begin
        field_next      = field_reg;
        name_len_next   = name_len_reg;
        name_match_next = name_match_reg;
        slash_next      = 1'b0;
        min_val_next    = min_val_reg;
        max_val_next    = max_val_reg;
        min_dig_next    = min_dig_reg;
        max_dig_next    = max_dig_reg;
        dig_err_next    = dig_err_reg;
        byte_cnt_next   = cnt_inc[CNT_W-1:0];
        if (is_sep) begin
            slash_next = 1'b1;
            field_next = (field_reg == vnp_pkg::FLD_NAME) ? vnp_pkg::FLD_MIN
                                                          : vnp_pkg::FLD_MAX;
        end else begin
            case (field_reg)
                vnp_pkg::FLD_NAME: begin
                    if (name_len_reg >= NAME_FULL ||
                        vnp_pkg::NAME_TAG[name_len_reg[2:0]] != rx_byte) begin
                        name_match_next = 1'b0;
                    end
                    if (name_len_reg != NAME_SAT) begin
                        name_len_next = name_len_reg + 1'b1;
                    end
                end
                vnp_pkg::FLD_MIN: begin
                    if (!is_digit) begin
                        dig_err_next = 1'b1;
                    end else if (min_dig_reg < DIG_LIMIT) begin
                        min_val_next = min_acc;
                    end
                    if (min_dig_reg != DIG_SAT) begin
                        min_dig_next = min_dig_reg + 1'b1;
                    end
                end
                default: begin
                    if (!is_digit) begin
                        dig_err_next = 1'b1;
                    end else if (max_dig_reg < DIG_LIMIT) begin
                        max_val_next = max_acc;
                    end
                    if (max_dig_reg != DIG_SAT) begin
                        max_dig_next = max_dig_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            byte_cnt_reg   <= '0;
            field_reg      <= vnp_pkg::FLD_NAME;
            name_len_reg   <= '0;
            name_match_reg <= 1'b1;
            slash_reg      <= 1'b0;
            min_val_reg    <= '0;
            max_val_reg    <= '0;
            min_dig_reg    <= '0;
            max_dig_reg    <= '0;
            dig_err_reg    <= 1'b0;
        end else if (step) begin
            byte_cnt_reg   <= byte_cnt_next;
            field_reg      <= field_next;
            name_len_reg   <= name_len_next;
            name_match_reg <= name_match_next;
            slash_reg      <= slash_next;
            min_val_reg    <= min_val_next;
            max_val_reg    <= max_val_next;
            min_dig_reg    <= min_dig_next;
            max_dig_reg    <= max_dig_next;
            dig_err_reg    <= dig_err_next;
        end
    end

    always_comb begin
        sum.field_index    = field_reg;
        sum.last_was_slash = slash_reg;
        sum.name_ok        = name_match_reg && (name_len_reg == NAME_FULL);
        sum.min_digits     = min_dig_reg;
        sum.max_digits     = max_dig_reg;
        sum.digit_error    = dig_err_reg;
        sum.min_value      = min_val_reg;
        sum.max_value      = max_val_reg;
    end

    vnp_match #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_match (
        .sum (sum),
        .cfg (cfg),
        .res (match_res)
    );

    always_comb begin
        res = '0;
        if (is_nl) begin
            res = match_res;
        end else if (is_bad) begin
            res.done_res = 1'b1;
            res.status   = vnp_pkg::ST_BADCHAR;
        end else if (too_long) begin
            res.done_res = 1'b1;
            res.status   = vnp_pkg::ST_TOOLONG;
        end else begin
            res.status = vnp_pkg::ST_BUSY;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/version_negotiation_parser.sv @@
// A byte's result is registered from the input stage into the output stage, which drives m_*.
// Throughput: one byte per cycle while m_* is not stalled; the line-state update is a single stage.
// Backpressure on m_* stalls both register stages; s_tready stays high
// while either stage can advance.
// Reset (aresetn low, synchronous): both stages empty, line state cleared,
// server_side 0, min_supported 1, max_supported 1.
// ----------------------------------------------------------------------------
// version_negotiation_parser
// Parses the received "name/min/max" line byte by byte and negotiates a version.
// ----------------------------------------------------------------------------
`default_nettype none

`include "version_negotiation_parser_assert.svh"

module version_negotiation_parser #(
    parameter int MAX_LINE   = vnp_pkg::DEF_MAX_LINE,
    parameter int MAX_DIGITS = vnp_pkg::DEF_MAX_DIGITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    // input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [31:0] negotiated_version, [63:32] reply_min,
                                        // [95:64] reply_max
    output logic [4:0]       m_tuser,   // [3:0] status, [4] send_reply
    output logic             m_tlast    // done_res
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    vnp_pkg::res_t out_res_reg;
    vnp_pkg::cfg_t cfg_reg;
    vnp_pkg::res_t line_res;
    logic          out_adv;
    logic          step;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign step     = in_valid_reg && out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.server_side   <= 1'b0;
            cfg_reg.min_supported <= vnp_pkg::RST_MIN_SUPPORTED;
            cfg_reg.max_supported <= vnp_pkg::RST_MAX_SUPPORTED;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                vnp_pkg::CFG_SERVER_SIDE:   cfg_reg.server_side   <= cfg_wdata[0];
                vnp_pkg::CFG_MIN_SUPPORTED: cfg_reg.min_supported <= cfg_wdata;
                vnp_pkg::CFG_MAX_SUPPORTED: cfg_reg.max_supported <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage: hold the byte until the line stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    vnp_line #(
        .MAX_LINE   (MAX_LINE),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (line_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= line_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.done_res;
    assign m_tuser  = {out_res_reg.send_reply, out_res_reg.status};
    assign m_tdata  = {out_res_reg.reply_max, out_res_reg.reply_min,
                       out_res_reg.negotiated_version};

    `VNP_ASSERT_SAME(a_busy_not_done, m_tvalid && !m_tlast,
        m_tuser[3:0] == vnp_pkg::ST_BUSY, "busy beat with nonzero status")
    `VNP_ASSERT_SAME(a_done_not_busy, m_tvalid && m_tlast,
        m_tuser[3:0] != vnp_pkg::ST_BUSY, "done beat reports busy")
    `VNP_ASSERT_SAME(a_reply_status, m_tvalid && m_tuser[4],
        m_tuser[3:0] == vnp_pkg::ST_OK || m_tuser[3:0] == vnp_pkg::ST_NOMATCH,
        "reply requested on a failed line")
    `VNP_ASSERT_SAME(a_version_only_ok, m_tvalid && m_tuser[3:0] != vnp_pkg::ST_OK,
        m_tdata[31:0] == '0, "version given without success")
    `VNP_ASSERT_NEXT(a_in_hold, in_valid_reg && !out_adv,
        in_valid_reg && $stable(in_byte_reg), "input stage lost a stalled byte")

endmodule

`default_nettype wire

@@ bench/tb_version_negotiation_parser.sv @@
// ----------------------------------------------------------------------------
// tb_version_negotiation_parser
// Streams handshake lines into the parser one byte per beat and checks every
// result beat against a cycle-free line parser kept in the bench. Covers
// framing errors, the server and client matching rules over several supported
// ranges, corrupted lines and random noise, under mixed idle and stall
// patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_version_negotiation_parser;

    localparam int          LINE_LIMIT    = vnp_pkg::DEF_MAX_LINE;
    localparam int          DIGIT_LIMIT   = vnp_pkg::DEF_MAX_DIGITS;
    localparam logic [31:0] PEER_TOP      = 32'd999_999_999;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          CYCLE_LIMIT   = 200_000;
    localparam int          REPORT_LIMIT  = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;   // [31:0] negotiated_version, [63:32] reply_min, [95:64] reply_max
    logic [4:0]  m_tuser;   // [3:0] status, [4] send_reply
    logic        m_tlast;

    version_negotiation_parser #(
        .MAX_LINE   (LINE_LIMIT),
        .MAX_DIGITS (DIGIT_LIMIT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Bench copy of the configuration registers
    logic        cfg_server  = 1'b0;
    logic [31:0] cfg_min_sup = vnp_pkg::RST_MIN_SUPPORTED;
    logic [31:0] cfg_max_sup = vnp_pkg::RST_MAX_SUPPORTED;

    // Bench copy of the line state
    int              ln_count;
    vnp_pkg::field_t ln_field;
    int              ln_name_len;
    logic            ln_name_ok;
    logic            ln_after_slash;
    logic            ln_bad_digit;
    logic [29:0]     ln_min_val;
    logic [29:0]     ln_max_val;
    int              ln_min_chars;
    int              ln_max_chars;

    vnp_pkg::res_t verdict_q [$];
    logic [7:0]    line_buf [$];

    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  hold_request   = 1'b0;
    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  bytes_sent     = 0;
    int  lines_sent     = 0;
    int  status_hits [16];

    function automatic void restart_line();
        ln_count       = 0;
        ln_field       = vnp_pkg::FLD_NAME;
        ln_name_len    = 0;
        ln_name_ok     = 1'b1;
        ln_after_slash = 1'b0;
        ln_bad_digit   = 1'b0;
        ln_min_val     = '0;
        ln_max_val     = '0;
        ln_min_chars   = 0;
        ln_max_chars   = 0;
    endfunction

    // Advance the line state by one byte and return the result beat it causes.
    function automatic vnp_pkg::res_t parse_byte(input logic [7:0] c);
        vnp_pkg::res_t r;
        logic [31:0]   peer_lo;
        logic [31:0]   peer_hi;
        logic [31:0]   lo;
        logic [31:0]   hi;
        logic          digit;
        r = '0;
        if (c == vnp_pkg::CHR_NL) begin
            r.done_res = 1'b1;
            peer_lo = {2'b00, ln_min_val};
            peer_hi = {2'b00, ln_max_val};
            if (ln_field == vnp_pkg::FLD_NAME ||
                (ln_field == vnp_pkg::FLD_MIN && ln_after_slash)) begin
                r.status = vnp_pkg::ST_SLASH1;
            end else if (ln_field == vnp_pkg::FLD_MIN || ln_after_slash) begin
                r.status = vnp_pkg::ST_SLASH2;
            end else if (!(ln_name_ok && ln_name_len == vnp_pkg::NAME_LEN)) begin
                r.status = vnp_pkg::ST_NAME;
            end else if (ln_min_chars > DIGIT_LIMIT) begin
                r.status = vnp_pkg::ST_MINLONG;
            end else if (ln_max_chars > DIGIT_LIMIT) begin
                r.status = vnp_pkg::ST_MAXLONG;
            end else if (ln_bad_digit) begin
                r.status = vnp_pkg::ST_BADDIGIT;
            end else if (cfg_server) begin
                if (peer_lo > peer_hi) begin
                    r.status = vnp_pkg::ST_WEIRD;
                end else begin
                    lo = (peer_lo > cfg_min_sup) ? peer_lo : cfg_min_sup;
                    hi = (peer_hi < cfg_max_sup) ? peer_hi : cfg_max_sup;
                    r.send_reply = 1'b1;
                    if (lo > hi) begin
                        r.status    = vnp_pkg::ST_NOMATCH;
                        r.reply_min = lo;
                        r.reply_max = hi;
                    end else begin
                        r.status             = vnp_pkg::ST_OK;
                        r.negotiated_version = hi;
                        r.reply_min          = hi;
                        r.reply_max          = hi;
                    end
                end
            end else begin
                if (peer_lo < cfg_min_sup || peer_hi > cfg_max_sup) begin
                    r.status = vnp_pkg::ST_ILLEGAL;
                end else if (peer_lo < peer_hi) begin
                    r.status = vnp_pkg::ST_WEIRD;
                end else if (peer_lo > peer_hi) begin
                    r.status = vnp_pkg::ST_NOMATCH;
                end else begin
                    r.status             = vnp_pkg::ST_OK;
                    r.negotiated_version = peer_lo;
                end
            end
            restart_line();
            return r;
        end
        if (c < vnp_pkg::CHR_SLASH || c > vnp_pkg::CHR_TOP) begin
            r.done_res = 1'b1;
            r.status   = vnp_pkg::ST_BADCHAR;
            restart_line();
            return r;
        end
        if (c == vnp_pkg::CHR_SLASH && ln_field != vnp_pkg::FLD_MAX) begin
            ln_field       = (ln_field == vnp_pkg::FLD_NAME) ? vnp_pkg::FLD_MIN
                                                             : vnp_pkg::FLD_MAX;
            ln_after_slash = 1'b1;
        end else begin
            ln_after_slash = 1'b0;
            digit = (c >= vnp_pkg::CHR_ZERO && c <= vnp_pkg::CHR_NINE);
            case (ln_field)
                vnp_pkg::FLD_NAME: begin
                    if (ln_name_len >= vnp_pkg::NAME_LEN ||
                        vnp_pkg::NAME_TAG[ln_name_len] != c)
                        ln_name_ok = 1'b0;
                    if (ln_name_len < 15) ln_name_len++;
                end
                vnp_pkg::FLD_MIN: begin
                    if (digit && ln_min_chars < DIGIT_LIMIT)
                        ln_min_val = 30'(ln_min_val * 10 + (c - vnp_pkg::CHR_ZERO));
                    if (!digit) ln_bad_digit = 1'b1;
                    if (ln_min_chars < 15) ln_min_chars++;
                end
                default: begin
                    if (digit && ln_max_chars < DIGIT_LIMIT)
                        ln_max_val = 30'(ln_max_val * 10 + (c - vnp_pkg::CHR_ZERO));
                    if (!digit) ln_bad_digit = 1'b1;
                    if (ln_max_chars < 15) ln_max_chars++;
                end
            endcase
        end
        ln_count++;
        if (ln_count >= LINE_LIMIT) begin
            r.done_res = 1'b1;
            r.status   = vnp_pkg::ST_TOOLONG;
            restart_line();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int held;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input vnp_pkg::res_t want,
                                   input vnp_pkg::res_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch (%s) at cycle %0d", what, cycle_count);
            $display("  expected done=%0b st=%0d ver=%0d reply=%0b rmin=%0d rmax=%0d",
                     want.done_res, want.status, want.negotiated_version,
                     want.send_reply, want.reply_min, want.reply_max);
            $display("  got      done=%0b st=%0d ver=%0d reply=%0b rmin=%0d rmax=%0d",
                     got.done_res, got.status, got.negotiated_version,
                     got.send_reply, got.reply_min, got.reply_max);
        end
    endtask

    always @(posedge aclk) begin : check_results
        vnp_pkg::res_t want;
        vnp_pkg::res_t got;
        logic          wrong;
        if (aresetn && m_tvalid && m_tready) begin
            got.done_res           = m_tlast;
            got.status             = vnp_pkg::status_t'(m_tuser[3:0]);
            got.send_reply         = m_tuser[4];
            got.negotiated_version = m_tdata[31:0];
            got.reply_min          = m_tdata[63:32];
            got.reply_max          = m_tdata[95:64];
            results_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected beat", '0, got);
            end else begin
                want  = verdict_q.pop_front();
                wrong = (got.done_res !== want.done_res)
                     || (got.status !== want.status)
                     || (got.negotiated_version !== want.negotiated_version)
                     || (got.send_reply !== want.send_reply)
                     || (got.reply_min !== want.reply_min)
                     || (got.reply_max !== want.reply_max);
                if (wrong) report_mismatch("field", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, verdict_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        vnp_pkg::res_t want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = parse_byte(b);
        verdict_q.push_back(want);
        status_hits[want.status]++;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        lines_sent++;
    endtask

    // Drop valid and hold until every result beat has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic srv, input logic [31:0] lo, input logic [31:0] hi);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= vnp_pkg::CFG_SERVER_SIDE;
        cfg_wdata <= {31'b0, srv};
        @(posedge aclk);
        cfg_addr  <= vnp_pkg::CFG_MIN_SUPPORTED;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_addr  <= vnp_pkg::CFG_MAX_SUPPORTED;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_server  = srv;
        cfg_min_sup = lo;
        cfg_max_sup = hi;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 49; sink_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 49; end
            default:       begin src_idle_pct = 8;  sink_stall_pct = 8;  end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Line generation
    // ------------------------------------------------------------------------
    function automatic int decimal_width(input logic [31:0] v);
        int n;
        n = 1;
        while (v >= 10) begin
            v = v / 10;
            n++;
        end
        return n;
    endfunction

    // Peer versions cluster around the supported bounds so every rule branch fires.
    function automatic logic [31:0] pick_version();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = PEER_TOP;
            2, 3:    v = cfg_min_sup + $urandom_range(0, 2) - 1;
            4, 5:    v = cfg_max_sup + $urandom_range(0, 2) - 1;
            6:       v = $urandom_range(0, 20);
            default: v = $urandom_range(0, PEER_TOP);
        endcase
        if (v > PEER_TOP) v = $urandom_range(0, PEER_TOP);
        return v;
    endfunction

    task automatic push_number(input logic [31:0] v);
        logic [7:0] digs [16];
        int         w;
        int         n;
        w = decimal_width(v);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(w, DIGIT_LIMIT) : w;
        // empty field stands for zero
        if (v == 0 && $urandom_range(0, 2) == 0) n = 0;
        for (int i = n - 1; i >= 0; i--) begin
            digs[i] = vnp_pkg::CHR_ZERO + 8'(v % 10);
            v = v / 10;
        end
        for (int i = 0; i < n; i++) line_buf.push_back(digs[i]);
    endtask

    task automatic build_line(input bit broken);
        logic [31:0] peer_lo;
        logic [31:0] peer_hi;
        int          pos;
        int          k;
        peer_lo = pick_version();
        peer_hi = ($urandom_range(0, 3) == 0) ? peer_lo : pick_version();
        line_buf.delete();
        for (int i = 0; i < vnp_pkg::NAME_LEN; i++) line_buf.push_back(vnp_pkg::NAME_TAG[i]);
        line_buf.push_back(vnp_pkg::CHR_SLASH);
        push_number(peer_lo);
        line_buf.push_back(vnp_pkg::CHR_SLASH);
        push_number(peer_hi);
        line_buf.push_back(vnp_pkg::CHR_NL);
        if (!broken) return;
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 7))
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1: line_buf.delete(pos);
            2: line_buf.insert(pos, vnp_pkg::CHR_SLASH);
            3: line_buf[$urandom_range(0, vnp_pkg::NAME_LEN - 1)] =
                   8'($urandom_range(8'h41, 8'h5A));
            // drop the newline so the next line runs on
            4: void'(line_buf.pop_back());
            5: begin
                k   = $urandom_range(1, 14);
                pos = $urandom_range(0, 1) ? vnp_pkg::NAME_LEN + 1 : line_buf.size() - 1;
                repeat (k) line_buf.insert(pos, vnp_pkg::CHR_ZERO);
            end
            6: line_buf.insert($urandom_range(vnp_pkg::NAME_LEN + 1, line_buf.size() - 1),
                               8'($urandom_range(vnp_pkg::CHR_SLASH, vnp_pkg::CHR_TOP)));
            default: begin
                if ($urandom_range(0, 1))
                    line_buf.delete($urandom_range(0, vnp_pkg::NAME_LEN - 1));
                else
                    line_buf.insert($urandom_range(0, vnp_pkg::NAME_LEN),
                                    8'($urandom_range(8'h41, 8'h5A)));
            end
        endcase
    endtask

    task automatic run_lines(input int count, input int broken_pct);
        repeat (count) begin
            build_line($urandom_range(0, 99) < broken_pct);
            send_line();
        end
    endtask

    // Two lines per idle mode for each supported range.
    task automatic sweep_ranges(input logic srv, input logic [31:0] lo_set [4],
                                input logic [31:0] hi_set [4]);
        for (int s = 0; s < 4; s++) begin
            set_config(srv, lo_set[s], hi_set[s]);
            for (int m = 0; m < 4; m++) begin
                set_idling(idle_mode_t'(m));
                run_lines(2, 15);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_framing_errors();
        set_idling(IDLE_NONE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(vnp_pkg::CHR_SLASH - 8'd1);
        send_byte(vnp_pkg::CHR_TOP + 8'd1);
        send_text("\n");
        send_text("/\n");
        send_text("/Z\n");
        send_text("//\n");
        send_text("//0\n");
        wait_for_results();
    endtask

    task automatic test_reset_defaults();
        for (int m = 0; m < 4; m++) begin
            set_idling(idle_mode_t'(m));
            run_lines(2, 15);
        end
    endtask

    task automatic test_server_rule();
        logic [31:0] lo_set [4];
        logic [31:0] hi_set [4];
        lo_set = '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd0};
        hi_set = '{32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0};
        lo_set[3] = $urandom_range(0, 40);
        hi_set[3] = lo_set[3] + $urandom_range(0, 40);
        sweep_ranges(1'b1, lo_set, hi_set);
    endtask

    task automatic test_client_rule();
        logic [31:0] lo_set [4];
        logic [31:0] hi_set [4];
        lo_set = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd0};
        hi_set = '{32'd5, 32'hFFFF_FFFF, 32'd0, 32'd0};
        lo_set[3] = $urandom_range(0, 20);
        hi_set[3] = lo_set[3] + $urandom_range(0, 6);
        sweep_ranges(1'b0, lo_set, hi_set);
    endtask

    task automatic test_malformed_lines();
        for (int i = 0; i < 20; i++) begin
            set_idling(idle_mode_t'(i % 4));
            if ($urandom_range(0, 1)) begin
                run_lines(1, 100);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 5) == 0)
                        send_byte(vnp_pkg::CHR_NL);
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        set_config(1'b1, 32'd2, 32'd9);
        set_idling(IDLE_NONE);
        hold_request = 1'b1;
        run_lines(4, 0);
        wait_for_results();
    endtask

    initial begin
        int errs;
        restart_line();
        foreach (status_hits[i]) status_hits[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_framing_errors();
        test_reset_defaults();
        test_server_rule();
        test_client_rule();
        test_malformed_lines();
        test_backpressure();

        wait_for_results();
        errs = 0;
        for (int s = vnp_pkg::ST_BADCHAR; s <= vnp_pkg::ST_BADDIGIT; s++)
            errs += status_hits[s];
        $display("Sent %0d bytes in %0d generated lines; both matching rules, four idle mixes",
                 bytes_sent, lines_sent);
        $display("Checked %0d beats: ok %0d, no match %0d, reversed %0d, illegal %0d, parse err %0d",
                 results_seen, status_hits[vnp_pkg::ST_OK], status_hits[vnp_pkg::ST_NOMATCH],
                 status_hits[vnp_pkg::ST_WEIRD], status_hits[vnp_pkg::ST_ILLEGAL], errs);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ version_negotiation_parser.f @@
+incdir+hw/rtl
hw/rtl/vnp_pkg.sv
hw/rtl/vnp_match.sv
hw/rtl/vnp_line.sv
hw/rtl/version_negotiation_parser.sv
bench/tb_version_negotiation_parser.sv
